[rtl/shamh_pkg.sv]
// ----------------------------------------------------------------------------
// shamh_pkg
// Shared types and constants for the SHA-256 message hasher: controller
// states, command and status bundles, round constants and initial hash.
// ----------------------------------------------------------------------------
package shamh_pkg;

  localparam int unsigned ROUNDS       = 64;
  localparam int unsigned DIGEST_WORDS = 8;
  localparam int unsigned BLK_WORDS    = 16;
  localparam int unsigned RND_W        = $clog2(ROUNDS);
  localparam int unsigned IDX_W        = $clog2(DIGEST_WORDS);
  localparam int unsigned WC_W         = $clog2(BLK_WORDS) + 1;

  localparam logic [RND_W-1:0] LAST_ROUND = RND_W'(ROUNDS - 1);
  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(DIGEST_WORDS - 1);
  // word slot where the 64-bit length starts
  localparam logic [WC_W-1:0]  LEN_SLOT   = WC_W'(BLK_WORDS - 2);
  localparam logic [WC_W-1:0]  LAST_SLOT  = WC_W'(BLK_WORDS - 1);
  localparam logic [WC_W-1:0]  FULL_SLOT  = WC_W'(BLK_WORDS);

  localparam logic [31:0] PAD_MARK = 32'h8000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PAD80,
    ST_PADZ,
    ST_LENHI,
    ST_LENLO,
    ST_LOADV,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } shamh_state_t;

  typedef struct packed {
    logic             load_word;
    logic             push_pad;
    logic             push_zero;
    logic             push_len_hi;
    logic             push_len_lo;
    logic             load_vars;
    logic             round_en;
    logic             fold;
    logic             clear;
    logic [RND_W-1:0] rnd;
    logic [IDX_W-1:0] out_idx;
  } shamh_cmd_t;

  typedef struct packed {
    logic wc14;       // 14 words held: length goes next
    logic wc15;       // one push completes the block
    logic word_done;  // incoming item completes a buffer word
  } shamh_sts_t;

  localparam logic [31:0] K_ROUND [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] H_INIT [DIGEST_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

endpackage

[rtl/shamh_ctrl.sv]
// ----------------------------------------------------------------------------
// shamh_ctrl
// Sequencer for the hasher: takes items, drives padding pushes, runs the
// 64 compression rounds and hands out the eight digest words.
// ----------------------------------------------------------------------------
module shamh_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_last_word,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  shamh_pkg::shamh_sts_t  sts,
  output shamh_pkg::shamh_cmd_t  cmd
);

  shamh_pkg::shamh_state_t           state_r, state_nxt;
  shamh_pkg::shamh_state_t           ret_r, ret_nxt;
  logic [shamh_pkg::RND_W-1:0]       rnd_r, rnd_nxt;
  logic [shamh_pkg::IDX_W-1:0]       idx_r, idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= shamh_pkg::ST_IDLE;
      ret_r   <= shamh_pkg::ST_IDLE;
      rnd_r   <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      rnd_r   <= rnd_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    ret_nxt     = ret_r;
    rnd_nxt     = rnd_r;
    idx_nxt     = idx_r;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd         = '0;
    cmd.rnd     = rnd_r;
    cmd.out_idx = idx_r;
    unique case (state_r)
      shamh_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_word = 1'b1;
          if (sts.word_done && sts.wc15) begin
            state_nxt = shamh_pkg::ST_LOADV;
            ret_nxt   = in_last_word ? shamh_pkg::ST_PAD80 : shamh_pkg::ST_IDLE;
          end else if (in_last_word) begin
            state_nxt = shamh_pkg::ST_PAD80;
          end
        end
      end
      shamh_pkg::ST_PAD80: begin
        cmd.push_pad = 1'b1;
        state_nxt    = sts.wc15 ? shamh_pkg::ST_LOADV : shamh_pkg::ST_PADZ;
        ret_nxt      = shamh_pkg::ST_PADZ;
      end
      shamh_pkg::ST_PADZ: begin
        if (sts.wc14) begin
          state_nxt = shamh_pkg::ST_LENHI;
        end else begin
          cmd.push_zero = 1'b1;
          ret_nxt       = shamh_pkg::ST_PADZ;
          if (sts.wc15) begin
            state_nxt = shamh_pkg::ST_LOADV;
          end
        end
      end
      shamh_pkg::ST_LENHI: begin
        cmd.push_len_hi = 1'b1;
        state_nxt       = shamh_pkg::ST_LENLO;
      end
      shamh_pkg::ST_LENLO: begin
        cmd.push_len_lo = 1'b1;
        state_nxt       = shamh_pkg::ST_LOADV;
        ret_nxt         = shamh_pkg::ST_OUT;
      end
      shamh_pkg::ST_LOADV: begin
        cmd.load_vars = 1'b1;
        rnd_nxt       = '0;
        state_nxt     = shamh_pkg::ST_ROUND;
      end
      shamh_pkg::ST_ROUND: begin
        cmd.round_en = 1'b1;
        rnd_nxt      = rnd_r + 1'b1;
        if (rnd_r == shamh_pkg::LAST_ROUND) begin
          state_nxt = shamh_pkg::ST_FOLD;
        end
      end
      shamh_pkg::ST_FOLD: begin
        cmd.fold  = 1'b1;
        idx_nxt   = '0;
        state_nxt = ret_r;
      end
      shamh_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          idx_nxt = idx_r + 1'b1;
          if (idx_r == shamh_pkg::LAST_IDX) begin
            cmd.clear = 1'b1;
            state_nxt = shamh_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = shamh_pkg::ST_IDLE;
      end
    endcase
  end

  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == shamh_pkg::ST_ROUND && rnd_r == shamh_pkg::LAST_ROUND
    |=> state_r == shamh_pkg::ST_FOLD)
    else $error("round count did not end in fold");

  a_digest_start: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == shamh_pkg::ST_FOLD && ret_r == shamh_pkg::ST_OUT
    |=> state_r == shamh_pkg::ST_OUT && idx_r == '0)
    else $error("digest did not start at word 0");

  a_digest_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == shamh_pkg::ST_OUT && out_ready && idx_r == shamh_pkg::LAST_IDX
    |=> state_r == shamh_pkg::ST_IDLE)
    else $error("no return to idle after last digest word");

endmodule

[rtl/shamh_datapath.sv]
// ----------------------------------------------------------------------------
// shamh_datapath
// Byte packer, 16-word message schedule shift line, round unit and hash
// state. Acts on commands from the controller.
// ----------------------------------------------------------------------------
module shamh_datapath (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [31:0]            in_data_word,
  input  logic [2:0]             in_byte_count,
  input  shamh_pkg::shamh_cmd_t  cmd,
  output shamh_pkg::shamh_sts_t  sts,
  output logic [31:0]            out_digest_word
);

  logic [31:0]                 w_r   [shamh_pkg::BLK_WORDS];
  logic [31:0]                 v_r   [shamh_pkg::DIGEST_WORDS];
  logic [31:0]                 h_r   [shamh_pkg::DIGEST_WORDS];
  logic [31:0]                 acc_r;
  logic [1:0]                  acc_n_r;
  logic [shamh_pkg::WC_W-1:0]  wc_r;
  logic [31:0]                 total_r;

  logic [2:0]  n_clamp;
  logic [2:0]  n_sum;
  logic [31:0] byte_mask;
  logic [63:0] packed_w;
  logic        push_en;
  logic [31:0] push_word;
  logic [31:0] t1, t2, w_new;

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  // byte packing: held bytes first, then the new item's valid bytes
  always_comb begin
    n_clamp = (in_byte_count > 3'd4) ? 3'd4 : in_byte_count;
    n_sum   = {1'b0, acc_n_r} + n_clamp;
    case (n_clamp)
      3'd0:    byte_mask = 32'h0000_0000;
      3'd1:    byte_mask = 32'hff00_0000;
      3'd2:    byte_mask = 32'hffff_0000;
      3'd3:    byte_mask = 32'hffff_ff00;
      default: byte_mask = 32'hffff_ffff;
    endcase
    packed_w = {acc_r, 32'h0} | ({in_data_word & byte_mask, 32'h0} >> {acc_n_r, 3'b000});
  end

  always_comb begin
    push_en   = 1'b1;
    push_word = 32'h0;
    if (cmd.load_word) begin
      push_en   = n_sum[2];
      push_word = packed_w[63:32];
    end else if (cmd.push_pad) begin
      push_word = acc_r | (shamh_pkg::PAD_MARK >> {acc_n_r, 3'b000});
    end else if (cmd.push_len_hi) begin
      push_word = {29'b0, total_r[31:29]};
    end else if (cmd.push_len_lo) begin
      push_word = {total_r[28:0], 3'b000};
    end else begin
      push_en = cmd.push_zero;
    end
  end

  assign sts.word_done = n_sum[2];
  assign sts.wc14      = (wc_r == shamh_pkg::LEN_SLOT);
  assign sts.wc15      = (wc_r == shamh_pkg::LAST_SLOT);

  // one round; w_r[0] holds W[t]
  always_comb begin
    t1 = v_r[7] + bsig1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
       + shamh_pkg::K_ROUND[cmd.rnd] + w_r[0];
    t2 = bsig0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
    w_new = ssig1(w_r[14]) + w_r[9] + ssig0(w_r[1]) + w_r[0];
  end

  always_ff @(posedge clk) begin
    if (push_en || cmd.round_en) begin
      for (int i = 0; i < shamh_pkg::BLK_WORDS - 1; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[shamh_pkg::BLK_WORDS-1] <= cmd.round_en ? w_new : push_word;
    end
    if (cmd.load_vars) begin
      for (int i = 0; i < shamh_pkg::DIGEST_WORDS; i++) begin
        v_r[i] <= h_r[i];
      end
    end else if (cmd.round_en) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      for (int i = 0; i < shamh_pkg::DIGEST_WORDS; i++) begin
        h_r[i] <= shamh_pkg::H_INIT[i];
      end
      acc_r   <= '0;
      acc_n_r <= '0;
      wc_r    <= '0;
      total_r <= '0;
    end else begin
      if (cmd.fold) begin
        for (int i = 0; i < shamh_pkg::DIGEST_WORDS; i++) begin
          h_r[i] <= h_r[i] + v_r[i];
        end
        wc_r <= '0;
      end else if (push_en) begin
        wc_r <= wc_r + 1'b1;
      end
      if (cmd.load_word) begin
        total_r <= total_r + 32'(n_clamp);
        if (n_sum[2]) begin
          acc_r   <= packed_w[31:0];
          acc_n_r <= n_sum[1:0];
        end else begin
          acc_r   <= packed_w[63:32];
          acc_n_r <= n_sum[1:0];
        end
      end else if (cmd.push_pad) begin
        acc_r   <= '0;
        acc_n_r <= '0;
      end
    end
  end

  assign out_digest_word = h_r[cmd.out_idx];

  a_wc_range: assert property (@(posedge clk) disable iff (!rst_n)
    wc_r <= shamh_pkg::FULL_SLOT)
    else $error("buffer word count beyond one block");

  a_full_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_vars |-> wc_r == shamh_pkg::FULL_SLOT)
    else $error("compression started on a partial block");

  a_acc_clean: assert property (@(posedge clk) disable iff (!rst_n)
    acc_n_r == 2'd0 |-> acc_r == 32'h0)
    else $error("stale bytes in empty pack register");

endmodule

[rtl/sha256_message_hasher.sv]
// ----------------------------------------------------------------------------
// sha256_message_hasher
// SHA-256 over a stream of big-endian words; gives the digest as eight items.
// ----------------------------------------------------------------------------
// Flow: a data item is taken while idle. Every 16th buffer word starts a
// compression (load, 64 rounds through the single round unit at one per
// cycle, fold into the hash), during which no item is taken. On the last
// item the block pushes the pad byte, zero words and the 64-bit length one
// word per cycle between compressions, with an idle step before the length,
// runs one or two compressions, then offers the eight digest words, one per
// cycle as they are taken; input waits until the eighth is taken, after
// which the hash returns to its initial value.
module sha256_message_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_byte_count,
  input  logic        in_last_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_digest_last
);

  shamh_pkg::shamh_cmd_t cmd;
  shamh_pkg::shamh_sts_t sts;

  shamh_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_last_word (in_last_word),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  shamh_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_data_word    (in_data_word),
    .in_byte_count   (in_byte_count),
    .cmd             (cmd),
    .sts             (sts),
    .out_digest_word (out_digest_word)
  );

  assign out_word_index  = cmd.out_idx;
  assign out_digest_last = (cmd.out_idx == shamh_pkg::LAST_IDX);

endmodule
